// File: hdl/bcrds_pkg.sv
`default_nettype none

package bcrds_pkg;

   // Defaults for the top-level parameters
   localparam int SCREEN_WIDTH_DEF = 320;
   localparam int BAND_HEIGHT_DEF  = 16;
   localparam int MAX_RADIUS_DEF   = 32;

   // Fixed field widths
   localparam int ROW_W      = 6;   // band row index
   localparam int RAD_W      = 7;   // clamped radius, up to 127
   localparam int YW         = 14;  // signed screen y work width
   localparam int XW         = 13;  // signed screen x work width
   localparam int DY_W       = 9;   // signed row offset from the disc center
   localparam int N_W        = 14;  // r*r - dy*dy
   localparam int SQRT_STEPS = 8;   // result bits of the square root

   localparam logic ACT_RECT = 1'b0;
   localparam logic ACT_DISC = 1'b1;

   typedef struct packed {
      logic               action;
      logic [11:0]        band_top;
      logic signed [11:0] rect_left;
      logic signed [11:0] rect_top;
      logic signed [11:0] rect_right;
      logic signed [11:0] rect_bottom;
      logic signed [11:0] disc_cx;
      logic signed [11:0] disc_cy;
      logic [7:0]         disc_radius;
      logic [15:0]        fill_color;
   } req_item_type;

   typedef struct packed {
      logic [5:0]  band_row;
      logic [9:0]  span_left;
      logic [9:0]  span_right;
      logic [15:0] span_color;
      logic        has_pixels;
      logic        last;
   } rsp_item_type;

   // Controller to datapath
   typedef struct packed {
      logic load;      // latch the accepted item
      logic calc;      // clip the shape's rows to the band, square the radius
      logic span_set;  // derive first and last band row
      logic issue;     // send one row token into the pipeline
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic last_row;   // the row token now issued is the item's final one
      logic pipe_busy;  // some row token is still in flight
   } ctrl_stat_type;

   // One row token in the square root pipeline
   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic             last;
      logic             empty;
      logic [15:0]      rad;   // radicand, consumed two bits a stage from the top
      logic [9:0]       rem;
      logic [7:0]       root;
   } pipe_type;

   // One digit of a restoring integer square root.
   function automatic pipe_type sqrt_step(pipe_type p);
      pipe_type    q;
      logic [11:0] cur;
      logic [11:0] trial;
      q     = p;
      cur   = {p.rem, p.rad[15:14]};
      trial = {2'b00, p.root, 2'b01};
      q.rad = {p.rad[13:0], 2'b00};
      if (cur >= trial) begin
         q.rem  = 10'(cur - trial);
         q.root = {p.root[6:0], 1'b1};
      end else begin
         q.rem  = cur[9:0];
         q.root = {p.root[6:0], 1'b0};
      end
      return q;
   endfunction

endpackage

`default_nettype wire

// File: hdl/band_clipped_rect_disc_spans.sv
`default_nettype none

// Filled rectangle / filled disc span generator for one screen band.
// Raise start with an item on req_item while busy is low; the item is taken at
// that edge and busy stays high until every span of it has been delivered. The
// block emits one span per covered band row, top to bottom, each on rsp_item for
// a single cycle marked by rsp_strobe; the receiver cannot stall, so capture
// every strobe. The final span of an item has last set. A row clipped away
// horizontally still comes out, with has_pixels low and zero x and color; a
// shape that misses the band gives exactly one all-zero span with last set.
// An item with N covered rows (1 to BAND_HEIGHT, or 1 when it misses) gives N
// spans, one span per cycle, and the next item is only taken once busy has
// fallen after the last of them. Between the accepting edge and the first span
// lie the row clipping (the calc and span_set states), the squaring stage, the
// eight-stage square root pipeline that yields the disc half-widths and the
// output register.
module band_clipped_rect_disc_spans #(
   parameter int SCREEN_WIDTH = bcrds_pkg::SCREEN_WIDTH_DEF,
   parameter int BAND_HEIGHT  = bcrds_pkg::BAND_HEIGHT_DEF,
   parameter int MAX_RADIUS   = bcrds_pkg::MAX_RADIUS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire bcrds_pkg::req_item_type req_item,
   output logic                         rsp_strobe,
   output bcrds_pkg::rsp_item_type      rsp_item
);
   import bcrds_pkg::*;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   // Sequence the item: latch, clip rows, then issue one row token per cycle
   bcrds_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat)
   );

   // Row range, half-width pipeline and horizontal clipping
   bcrds_dpath #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .BAND_HEIGHT  (BAND_HEIGHT),
      .MAX_RADIUS   (MAX_RADIUS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

`default_nettype wire

// File: hdl/bcrds_ctrl.sv
`default_nettype none

module bcrds_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   output bcrds_pkg::ctrl_cmd_type      cmd,
   input  wire bcrds_pkg::ctrl_stat_type stat
);
   import bcrds_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_SPAN,
      ST_RUN,
      ST_DRAIN
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (start) state_in = ST_CALC;
         ST_CALC:  state_in = ST_SPAN;
         ST_SPAN:  state_in = ST_RUN;
         ST_RUN:   if (stat.last_row) state_in = ST_DRAIN;
         ST_DRAIN: if (!stat.pipe_busy) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
      busy_in = (state_in != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy         = busy_ff;
   assign cmd.load     = start && !busy_ff;
   assign cmd.calc     = (state_ff == ST_CALC);
   assign cmd.span_set = (state_ff == ST_SPAN);
   assign cmd.issue    = (state_ff == ST_RUN);

endmodule

`default_nettype wire

// File: hdl/bcrds_dpath.sv
`default_nettype none

module bcrds_dpath #(
   parameter int SCREEN_WIDTH = bcrds_pkg::SCREEN_WIDTH_DEF,
   parameter int BAND_HEIGHT  = bcrds_pkg::BAND_HEIGHT_DEF,
   parameter int MAX_RADIUS   = bcrds_pkg::MAX_RADIUS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire bcrds_pkg::req_item_type  req_item,
   input  wire bcrds_pkg::ctrl_cmd_type  cmd,
   output bcrds_pkg::ctrl_stat_type      stat,
   output logic                          rsp_strobe,
   output bcrds_pkg::rsp_item_type       rsp_item
);
   import bcrds_pkg::*;

   localparam logic signed [YW-1:0] BAND_LAST = YW'(BAND_HEIGHT - 1);
   localparam logic signed [XW-1:0] X_LAST    = XW'(SCREEN_WIDTH - 1);
   localparam logic [7:0]           R_MAX     = 8'(MAX_RADIUS);

   // Item registers
   logic               mode_ff;
   logic [11:0]        btop_ff;
   logic signed [11:0] xl_ff, xr_ff, yt_ff, yb_ff, cx_ff, cy_ff;
   logic [RAD_W-1:0]   rad_ff, rad_in;
   logic [15:0]        color_ff;

   // Row range
   logic signed [YW-1:0] ytop_ff, ybot_ff, ytop_in, ybot_in;
   logic signed [YW-1:0] btop_s, cy_s, rad_s, shape_top, shape_bot, band_bot;
   logic [N_W-1:0]       rsq_ff;
   logic                 empty_ff;
   logic [ROW_W-1:0]     row_ff, row_last_ff;
   logic signed [DY_W-1:0] dy_ff;

   // Pipeline
   logic signed [2*DY_W-1:0] dy_sq;
   logic signed [2*DY_W-1:0] n_full;
   pipe_type                 tok0;
   pipe_type                 pipe_ff [SQRT_STEPS+1];
   logic [SQRT_STEPS:0]      v_ff;

   // Output
   pipe_type             fin;
   logic [7:0]           hw;
   logic signed [XW-1:0] cx13, hw13, x0, x1, x0c, x1c;
   logic                 pix;
   rsp_item_type         rsp_in, rsp_ff;
   logic                 rsp_strobe_ff;

   // Clamp the radius into one through the maximum
   always_comb begin
      if (req_item.disc_radius == 8'd0) rad_in = RAD_W'(1);
      else if (req_item.disc_radius > R_MAX) rad_in = RAD_W'(MAX_RADIUS);
      else rad_in = req_item.disc_radius[RAD_W-1:0];
   end

   always_comb begin
      btop_s    = $signed({2'b00, btop_ff});
      cy_s      = $signed({{(YW-12){cy_ff[11]}}, cy_ff});
      rad_s     = $signed({{(YW-RAD_W){1'b0}}, rad_ff});
      band_bot  = btop_s + BAND_LAST;
      shape_top = (mode_ff == ACT_DISC) ? cy_s - rad_s
                                        : $signed({{(YW-12){yt_ff[11]}}, yt_ff});
      shape_bot = (mode_ff == ACT_DISC) ? cy_s + rad_s
                                        : $signed({{(YW-12){yb_ff[11]}}, yb_ff});
      ytop_in   = (shape_top > btop_s) ? shape_top : btop_s;
      ybot_in   = (shape_bot < band_bot) ? shape_bot : band_bot;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= req_item.action;
         btop_ff  <= req_item.band_top;
         xl_ff    <= req_item.rect_left;
         xr_ff    <= req_item.rect_right;
         yt_ff    <= req_item.rect_top;
         yb_ff    <= req_item.rect_bottom;
         cx_ff    <= req_item.disc_cx;
         cy_ff    <= req_item.disc_cy;
         rad_ff   <= rad_in;
         color_ff <= req_item.fill_color;
      end
      if (cmd.calc) begin
         ytop_ff <= ytop_in;
         ybot_ff <= ybot_in;
         rsq_ff  <= N_W'({{(N_W-RAD_W){1'b0}}, rad_ff} * {{(N_W-RAD_W){1'b0}}, rad_ff});
      end
      if (cmd.span_set) begin
         empty_ff    <= (ytop_ff > ybot_ff);
         row_ff      <= ROW_W'(ytop_ff - btop_s);
         row_last_ff <= ROW_W'(ybot_ff - btop_s);
         dy_ff       <= DY_W'(ytop_ff - cy_s);
      end else if (cmd.issue) begin
         row_ff <= row_ff + ROW_W'(1);
         dy_ff  <= dy_ff + DY_W'(1);
      end
   end

   assign stat.last_row  = empty_ff || (row_ff == row_last_ff);
   assign stat.pipe_busy = |v_ff;

   // Row token: radicand is 4*(r*r - dy*dy)
   always_comb begin
      dy_sq      = dy_ff * dy_ff;
      n_full     = $signed({{(2*DY_W-N_W){1'b0}}, rsq_ff}) - dy_sq;
      tok0.row   = row_ff;
      tok0.last  = stat.last_row;
      tok0.empty = empty_ff;
      tok0.rad   = {n_full[N_W-1:0], 2'b00};
      tok0.rem   = '0;
      tok0.root  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else v_ff <= {v_ff[SQRT_STEPS-1:0], cmd.issue};
   end

   always_ff @(posedge clock) begin
      pipe_ff[0] <= tok0;
      for (int k = 1; k <= SQRT_STEPS; k++) begin
         pipe_ff[k] <= sqrt_step(pipe_ff[k-1]);
      end
   end

   // floor(sqrt(4n)) plus one, halved, is sqrt(n) rounded half up
   always_comb begin
      fin  = pipe_ff[SQRT_STEPS];
      hw   = 8'(({1'b0, fin.root} + 9'd1) >> 1);
      cx13 = $signed({{(XW-12){cx_ff[11]}}, cx_ff});
      hw13 = $signed({{(XW-8){1'b0}}, hw});
      if (mode_ff == ACT_DISC) begin
         x0 = cx13 - hw13;
         x1 = cx13 + hw13;
      end else begin
         x0 = $signed({{(XW-12){xl_ff[11]}}, xl_ff});
         x1 = $signed({{(XW-12){xr_ff[11]}}, xr_ff});
      end
      x0c = (x0 < 0) ? '0 : x0;
      x1c = (x1 > X_LAST) ? X_LAST : x1;
      pix = !fin.empty && (x0c <= x1c);

      rsp_in.band_row   = fin.empty ? '0 : fin.row;
      rsp_in.span_left  = pix ? x0c[9:0] : '0;
      rsp_in.span_right = pix ? x1c[9:0] : '0;
      rsp_in.span_color = pix ? color_ff : '0;
      rsp_in.has_pixels = pix;
      rsp_in.last       = fin.last;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_strobe_ff <= 1'b0;
      else rsp_strobe_ff <= v_ff[SQRT_STEPS];
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

`default_nettype wire

// File: hdl/bcrds_checker.sv
`default_nettype none

module bcrds_checker (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    start,
   input wire logic                    busy,
   input wire bcrds_pkg::rsp_item_type rsp_item,
   input wire logic                    rsp_strobe
);
   import bcrds_pkg::*;

   // An accepted item makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("item accepted but busy did not rise");

   // Spans only come out while an item is in progress
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("span strobed while idle");

   // Nothing follows the last span of an item directly
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.last |=> !rsp_strobe)
      else $error("span right after last");

   // A span with pixels is ordered, an empty one carries zero x and color
   a_span_order: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.has_pixels |-> rsp_item.span_left <= rsp_item.span_right)
      else $error("span left beyond right");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.has_pixels |->
         rsp_item.span_left == 10'd0 && rsp_item.span_right == 10'd0 &&
         rsp_item.span_color == 16'd0)
      else $error("empty span carries data");

endmodule

bind band_clipped_rect_disc_spans bcrds_checker u_bcrds_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_item   (rsp_item),
   .rsp_strobe (rsp_strobe)
);

`default_nettype wire

// File: verif/band_clipped_rect_disc_spans_tb.sv
`default_nettype none

module band_clipped_rect_disc_spans_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bcrds_pkg::*;

   localparam int SCR_W        = SCREEN_WIDTH_DEF;
   localparam int BAND_H       = BAND_HEIGHT_DEF;
   localparam int RAD_MAX      = MAX_RADIUS_DEF;
   localparam int RAND_ITEMS   = 460;
   localparam int NUM_PHASES   = 4;
   localparam int DRAIN_CYCLES = 30;   // longer than the lag from acceptance to the first span
   localparam int MAX_REPORTS  = 10;

   // One row of the directed plan: an item, and optionally a typed-in span
   // that replaces the predictor for items with an obvious single result.
   typedef struct {
      req_item_type item;
      bit           typed;
      rsp_item_type span;
   } plan_row_type;

   logic         clock    = 1'b0;
   logic         reset    = 1'b1;
   logic         start    = 1'b0;
   req_item_type req_item = '0;
   logic         busy;
   logic         rsp_strobe;
   rsp_item_type rsp_item;

   rsp_item_type exp_spans[$];   // spans owed by the block, oldest first
   plan_row_type plan[$];

   int idle_pct;
   int err_count    = 0;
   int spans_seen   = 0;
   int items_sent   = 0;
   int rect_items   = 0;
   int disc_items   = 0;
   int band_misses  = 0;
   int empty_rows   = 0;

   band_clipped_rect_disc_spans #(
      .SCREEN_WIDTH (SCR_W),
      .BAND_HEIGHT  (BAND_H),
      .MAX_RADIUS   (RAD_MAX)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always #5 clock = ~clock;

   // Build one span the way the block reports it: a span with no pixels
   // carries zero x and color.
   function automatic rsp_item_type make_span(input int row, input int xl, input int xr,
                                              input int color, input bit last);
      rsp_item_type s;
      bit           pix;
      pix          = (xl <= xr);
      s.band_row   = ROW_W'(row);
      s.span_left  = pix ? 10'(xl) : 10'd0;
      s.span_right = pix ? 10'(xr) : 10'd0;
      s.span_color = pix ? 16'(color) : 16'd0;
      s.has_pixels = pix;
      s.last       = last;
      return s;
   endfunction

   // round(sqrt(n)) with halves rounded up: largest h with (2h-1)^2 <= 4n.
   function automatic int disc_half_width(input int n);
      int h;
      h = 0;
      if (n > 0) begin
         while ((2 * h + 1) * (2 * h + 1) <= 4 * n) h++;
      end
      return h;
   endfunction

   // Work out every span an accepted item owes and queue them in order.
   function automatic void predict_spans(input req_item_type it);
      int btop, bbot, x0, x1, y0, y1, cx, cy, r, d0, d1, hw;
      btop = it.band_top;
      bbot = btop + BAND_H - 1;
      if (it.action == ACT_RECT) begin
         rect_items++;
         x0 = $signed(it.rect_left);
         y0 = $signed(it.rect_top);
         x1 = $signed(it.rect_right);
         y1 = $signed(it.rect_bottom);
         if (x0 < 0) x0 = 0;
         if (x1 > SCR_W - 1) x1 = SCR_W - 1;
         if (y0 < btop) y0 = btop;
         if (y1 > bbot) y1 = bbot;
         if (y0 > y1) begin
            band_misses++;
            exp_spans.push_back(make_span(0, 1, 0, 0, 1'b1));
         end else begin
            for (int y = y0; y <= y1; y++) begin
               if (x0 > x1) empty_rows++;
               exp_spans.push_back(make_span(y - btop, x0, x1, it.fill_color, y == y1));
            end
         end
      end else begin
         disc_items++;
         cx = $signed(it.disc_cx);
         cy = $signed(it.disc_cy);
         r  = it.disc_radius;
         if (r < 1) r = 1;
         if (r > RAD_MAX) r = RAD_MAX;
         d0 = -r;
         d1 = r;
         if (cy + d0 < btop) d0 = btop - cy;
         if (cy + d1 > bbot) d1 = bbot - cy;
         if (d0 > d1) begin
            band_misses++;
            exp_spans.push_back(make_span(0, 1, 0, 0, 1'b1));
         end else begin
            for (int dy = d0; dy <= d1; dy++) begin
               hw = disc_half_width(r * r - dy * dy);
               x0 = (cx - hw < 0) ? 0 : cx - hw;
               x1 = (cx + hw > SCR_W - 1) ? SCR_W - 1 : cx + hw;
               if (x0 > x1) empty_rows++;
               exp_spans.push_back(make_span(cy + dy - btop, x0, x1, it.fill_color,
                                             dy == d1));
            end
         end
      end
   endfunction

   function automatic req_item_type rect_item(input int btop, input int l, input int t,
                                              input int r, input int b, input int color);
      req_item_type it;
      it             = '0;
      it.action      = ACT_RECT;
      it.band_top    = 12'(btop);
      it.rect_left   = 12'(l);
      it.rect_top    = 12'(t);
      it.rect_right  = 12'(r);
      it.rect_bottom = 12'(b);
      it.fill_color  = 16'(color);
      return it;
   endfunction

   function automatic req_item_type disc_item(input int btop, input int cx, input int cy,
                                              input int rad, input int color);
      req_item_type it;
      it             = '0;
      it.action      = ACT_DISC;
      it.band_top    = 12'(btop);
      it.disc_cx     = 12'(cx);
      it.disc_cy     = 12'(cy);
      it.disc_radius = 8'(rad);
      it.fill_color  = 16'(color);
      return it;
   endfunction

   function automatic void add_row(input req_item_type it, input bit typed,
                                   input rsp_item_type span);
      plan_row_type p;
      p.item  = it;
      p.typed = typed;
      p.span  = span;
      plan.push_back(p);
   endfunction

   // Random item: mostly shapes placed around the band so that they clip in
   // interesting ways, the rest raw noise over every bit of every field.
   function automatic req_item_type random_item();
      req_item_type it;
      logic [127:0] raw;
      int           btop, t, l;
      raw = {$urandom, $urandom, $urandom, $urandom};
      it  = raw[$bits(req_item_type)-1:0];
      if ($urandom_range(99) < 75) begin
         btop        = $urandom_range(0, 2000);
         it.band_top = 12'(btop);
         if (it.action == ACT_RECT) begin
            t              = btop + $urandom_range(0, 2 * BAND_H + 10) - BAND_H - 5;
            l              = $urandom_range(0, SCR_W + 80) - 40;
            it.rect_top    = 12'(t);
            it.rect_bottom = 12'(t + $urandom_range(0, 2 * BAND_H) - 2);
            it.rect_left   = 12'(l);
            it.rect_right  = 12'(l + $urandom_range(0, 200) - 10);
         end else begin
            it.disc_cy = 12'(btop + $urandom_range(0, BAND_H + 2 * RAD_MAX + 8)
                              - RAD_MAX - 4);
            it.disc_cx = 12'($urandom_range(0, SCR_W + 80) - 40);
            if ($urandom_range(99) < 85)
               it.disc_radius = 8'($urandom_range(0, RAD_MAX + 4));
         end
      end
      return it;
   endfunction

   // Offer one item and hold start until the block takes it. busy is read
   // right after the edge, so it is the value that decided acceptance.
   task automatic send_item(input req_item_type it, input bit typed,
                            input rsp_item_type span);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
      end
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      if (typed) exp_spans.push_back(span);
      else predict_spans(it);
      items_sent++;
   endtask

   // Hold the sender off until every owed span has come back.
   task automatic drain_spans();
      start <= 1'b0;
      while (exp_spans.size() != 0) @(posedge clock);
   endtask

   // Check each strobed span against the oldest expectation, field by field.
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_strobe) begin
         spans_seen++;
         if (exp_spans.size() == 0) begin
            err_count++;
            if (err_count <= MAX_REPORTS) begin
               $display("ERROR %0t: span with nothing owed", $realtime);
               $display("   actual   row %0d x %0d..%0d color %h pix %b last %b",
                        rsp_item.band_row, rsp_item.span_left,
                        rsp_item.span_right, rsp_item.span_color, rsp_item.has_pixels,
                        rsp_item.last);
            end
         end else begin
            want = exp_spans.pop_front();
            if (rsp_item.band_row   !== want.band_row   ||
                rsp_item.span_left  !== want.span_left  ||
                rsp_item.span_right !== want.span_right ||
                rsp_item.span_color !== want.span_color ||
                rsp_item.has_pixels !== want.has_pixels ||
                rsp_item.last       !== want.last) begin
               err_count++;
               if (err_count <= MAX_REPORTS) begin
                  $display("ERROR %0t: span mismatch", $realtime);
                  $display("   expected row %0d x %0d..%0d color %h pix %b last %b",
                           want.band_row, want.span_left, want.span_right,
                           want.span_color, want.has_pixels, want.last);
                  $display("   actual   row %0d x %0d..%0d color %h pix %b last %b",
                           rsp_item.band_row, rsp_item.span_left, rsp_item.span_right,
                           rsp_item.span_color, rsp_item.has_pixels, rsp_item.last);
               end
            end
         end
      end
   end

   // Hard limit on run length.
   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $display("   timeout with %0d spans still owed", exp_spans.size());
      $finish;
   end

   initial begin
      rsp_item_type miss;
      rsp_item_type none;
      int           per_phase;
      miss      = make_span(0, 1, 0, 0, 1'b1);
      none      = '0;
      per_phase = RAND_ITEMS / NUM_PHASES;

      // Directed plan: clipping extremes, both shapes, every special case.
      // Rectangle well inside the band: all sixteen rows.
      add_row(rect_item(100, 10, 100, 50, 115, 'h1234), 0, none);
      // Rectangle entirely above, then entirely below the band.
      add_row(rect_item(100, 10, 0, 50, 50, 'h5555), 1, miss);
      add_row(rect_item(100, 10, 200, 50, 300, 'h5555), 1, miss);
      // Inverted horizontally on one row: row emitted without pixels.
      add_row(rect_item(100, 60, 105, 20, 105, 'hBEEF), 1, make_span(5, 1, 0, 0, 1'b1));
      // Inverted horizontally over several rows.
      add_row(rect_item(100, 60, 98, 20, 108, 'hBEEF), 0, none);
      // Inverted vertically: covers nothing.
      add_row(rect_item(100, 10, 110, 50, 104, 'hBEEF), 1, miss);
      // Coordinate extremes: clipped to the band and the full screen width.
      add_row(rect_item(0, -2048, -2048, 2047, 2047, 'hFFFF), 0, none);
      // Off the left edge, then off the right edge: rows without pixels.
      add_row(rect_item(40, -100, 30, -1, 60, 'h00FF), 0, none);
      add_row(rect_item(40, SCR_W, 30, 2047, 60, 'h00FF), 0, none);
      // Single row, in the screen: read straight off.
      add_row(rect_item(0, 10, 5, 20, 5, 'hFFFF), 1, make_span(5, 10, 20, 'hFFFF, 1'b1));
      // Band at the highest band_top: no rectangle or disc can reach it.
      add_row(rect_item(4095, -2048, -2048, 2047, 2047, 'h0001), 1, miss);
      add_row(disc_item(4095, 100, 2047, 255, 'h0001), 1, miss);
      // Disc radius zero saturates to one; 255 saturates to the maximum.
      add_row(disc_item(0, 100, 8, 0, 'h0000), 0, none);
      add_row(disc_item(0, 100, 8, 255, 'hA5A5), 0, none);
      add_row(disc_item(20, 150, 28, RAD_MAX, 'h5A5A), 0, none);
      add_row(disc_item(20, 150, 28, RAD_MAX + 1, 'h5A5A), 0, none);
      // Disc clipped at the left and right screen edges.
      add_row(disc_item(0, 0, 8, 10, 'h1111), 0, none);
      add_row(disc_item(0, SCR_W - 1, 8, 10, 'h2222), 0, none);
      add_row(disc_item(0, SCR_W, 8, 10, 'h3333), 0, none);
      // Disc far off the screen horizontally: rows without pixels.
      add_row(disc_item(0, -2048, 8, 20, 'h4444), 0, none);
      add_row(disc_item(0, 2047, 8, 20, 'h4444), 0, none);
      // Disc far above the band.
      add_row(disc_item(500, 100, -2048, 32, 'h6666), 1, miss);
      // Disc crossing the band top and the band bottom.
      add_row(disc_item(200, 160, 195, 10, 'h7777), 0, none);
      add_row(disc_item(200, 160, 220, 10, 'h8888), 0, none);
      // Unit disc whose bottom row just touches the band: one pixel wide.
      add_row(disc_item(50, 7, 49, 1, 'hABCD), 1, make_span(0, 7, 7, 'hABCD, 1'b1));

      // Hold reset, then release it at an edge.
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed plan back to back.
      idle_pct = 0;
      foreach (plan[i]) send_item(plan[i].item, plan[i].typed, plan[i].span);
      drain_spans();

      // Random phases: no idling, sender idle most of the time, no idling
      // again, then light idling. Drain between phases so the sender also
      // waits out a completely empty block.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            1:       idle_pct = 77;
            3:       idle_pct = 20;
            default: idle_pct = 0;
         endcase
         for (int n = 0; n < per_phase; n++) send_item(random_item(), 0, none);
         drain_spans();
      end

      // Let any stray span surface before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d items (%0d rect, %0d disc predicted), %0d band misses, %0d empty rows",
               items_sent, rect_items, disc_items, band_misses, empty_rows);
      $display("Checked %0d spans over %0d passes; %0d mismatches",
               spans_seen, NUM_PHASES + 1, err_count);
      if (err_count == 0 && exp_spans.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
